// ----- hw/rtl/kic_pkg.sv -----
// Shared types, keyword tables and trivial-word trie for the keyword intent classifier.
// Used by kic_word_matcher, kic_trivial_matcher and keyword_intent_classifier.
package kic_pkg;

   localparam int KwCount   = 32;
   localparam int TrNodes   = 32;
   localparam int LimitW    = 6;
   localparam int CsrIndexW = 4;

   localparam logic [LimitW-1:0] SHORT_LIMIT_RESET = 6'd30;
   localparam logic [LimitW-1:0] TINY_LIMIT_RESET  = 6'd8;

   localparam logic [CsrIndexW-1:0] CSR_SHORT_LIMIT = 4'd0;
   localparam logic [CsrIndexW-1:0] CSR_TINY_LIMIT  = 4'd1;

   typedef enum logic [2:0] {
      INTENT_TRIVIAL  = 3'd0,
      INTENT_CODE     = 3'd1,
      INTENT_DECISION = 3'd2,
      INTENT_DEBUG    = 3'd3,
      INTENT_DEFAULT  = 3'd4
   } intent_type;

   typedef enum logic [2:0] {
      KIND_CODE  = 3'd0,
      KIND_DEC   = 3'd1,
      KIND_DEBUG = 3'd2,
      KIND_NEW   = 3'd3,
      KIND_NOUN  = 3'd4,
      KIND_OFF   = 3'd5
   } kw_kind_type;

   typedef logic [95:0] kw_text_type;

   typedef struct packed {
      logic code;
      logic decision;
      logic debug;
   } hits_type;

   typedef struct packed {
      logic [LimitW-1:0] count;
      logic              seen_question;
      logic              word_ok;
   } triv_status_type;

   // Text right-aligned: last character in the low byte. '*' is any word character.
   localparam kw_text_type KW_TEXT [KwCount] = '{
      96'("bug"), 96'("error"), 96'("fail"), 96'("broken"), 96'("crash"),
      96'("traceback"), 96'("fix"), 96'("exception"), 96'("segfault"),
      96'("unauthorized"), 96'("denied"),
      96'("implement"), 96'("add"), 96'("create"), 96'("build"), 96'("refactor"),
      96'("wrapper"),
      96'("should"), 96'("best"), 96'("design"), 96'("architect"), 96'("choose"),
      96'("prefer"), 96'("recommend"), 96'("tradeoff"), 96'("trade*off"),
      96'("new"), 96'("feature"), 96'("cmd"), 96'("file"), 96'("module"), 96'("off")
   };

   localparam logic [3:0] KW_LEN [KwCount] = '{
      4'd3, 4'd5, 4'd4, 4'd6, 4'd5, 4'd9, 4'd3, 4'd9, 4'd8, 4'd12, 4'd6,
      4'd9, 4'd3, 4'd6, 4'd5, 4'd8, 4'd7,
      4'd6, 4'd4, 4'd6, 4'd9, 4'd6, 4'd6, 4'd9, 4'd8, 4'd9,
      4'd3, 4'd7, 4'd3, 4'd4, 4'd6, 4'd3
   };

   localparam kw_kind_type KW_KIND [KwCount] = '{
      KIND_DEBUG, KIND_DEBUG, KIND_DEBUG, KIND_DEBUG, KIND_DEBUG, KIND_DEBUG,
      KIND_DEBUG, KIND_DEBUG, KIND_DEBUG, KIND_DEBUG, KIND_DEBUG,
      KIND_CODE, KIND_CODE, KIND_CODE, KIND_CODE, KIND_CODE, KIND_CODE,
      KIND_DEC, KIND_DEC, KIND_DEC, KIND_DEC, KIND_DEC, KIND_DEC, KIND_DEC,
      KIND_DEC, KIND_DEC,
      KIND_NEW, KIND_NOUN, KIND_NOUN, KIND_NOUN, KIND_NOUN, KIND_OFF
   };

   // "tradeoff" entry; a candidate of it at length five means the word was "trade"
   localparam int KwTradeoff = 24;

   // Trivial-word trie, nodes 1..32; node 0 is the leading-whitespace root.
   localparam logic [5:0] TV_ROOT        = 6'd0;
   localparam logic [5:0] TV_LAST_NODE   = 6'd32;
   localparam logic [5:0] TV_AFTER_WORD  = 6'd33;
   localparam logic [5:0] TV_AFTER_PUNCT = 6'd34;
   localparam logic [5:0] TV_DEAD        = 6'd35;

   localparam logic [5:0] TR_PARENT [1:TrNodes] = '{
      6'd0, 6'd1, 6'd0, 6'd3, 6'd0, 6'd5, 6'd0, 6'd7, 6'd8, 6'd9, 6'd10,
      6'd0, 6'd12, 6'd13, 6'd14, 6'd12, 6'd16, 6'd17,
      6'd0, 6'd19, 6'd20, 6'd21, 6'd22, 6'd23, 6'd24, 6'd25,
      6'd0, 6'd27, 6'd28, 6'd29, 6'd30, 6'd31
   };

   localparam logic [7:0] TR_CHAR [1:TrNodes] = '{
      "y", "a", "o", "k", "n", "o", "t", "i", "d", "a", "k",
      "s", "k", "i", "p", "t", "o", "p",
      "c", "o", "n", "t", "i", "n", "u", "e",
      "l", "a", "n", "j", "u", "t"
   };

   // accepting nodes: ya y ok no n tidak skip stop continue lanjut
   localparam logic [63:0] TR_ACC = 64'h0000_0001_0404_8876;

   function automatic logic [7:0] fold_lower(input logic [7:0] b);
      return (b >= "A" && b <= "Z") ? b + 8'd32 : b;
   endfunction

   function automatic logic is_ws(input logic [7:0] c);
      return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
   endfunction

   function automatic logic is_word(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "0" && c <= "9") || c == "_";
   endfunction

   function automatic logic is_punct(input logic [7:0] c);
      return c == "?" || c == "!" || c == ".";
   endfunction

endpackage

// ----- hw/rtl/kic_word_matcher.sv -----
// Whole-word keyword matcher: candidate mask, word position, phrase tracking, class hits.
// Depends on kic_pkg.
module kic_word_matcher import kic_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       take,
   input  logic       finish,
   input  logic [7:0] c,
   output hits_type   final_hits
);

   typedef struct packed {
      hits_type hits;
      logic     was_new;
      logic     was_trade;
   } close_type;

   logic [KwCount-1:0] cand_ff, cand_in;
   logic [3:0]         pos_ff, pos_in;
   logic               prev_ff, prev_in;
   logic [1:0]         new_ff, new_in;
   logic [1:0]         trd_ff, trd_in;
   hits_type           hits_ff, hits_in;
   close_type          cw_byte, cw_end;

   function automatic logic [7:0] kw_char(input int k, input logic [3:0] p);
      logic [3:0] idx;
      idx = KW_LEN[k] - 4'd1 - p;
      return KW_TEXT[k][{idx, 3'b000} +: 8];
   endfunction

   function automatic close_type close_word(input logic [KwCount-1:0] cand,
                                            input logic [3:0] p,
                                            input logic [1:0] nst,
                                            input logic [1:0] tst);
      close_type r;
      r = '0;
      for (int k = 0; k < KwCount; k++) begin
         if (cand[k]) begin
            if (k == KwTradeoff && p == 4'd5) r.was_trade = 1'b1;
            if (KW_LEN[k] == p) begin
               case (KW_KIND[k])
                  KIND_CODE:  r.hits.code = 1'b1;
                  KIND_DEC:   r.hits.decision = 1'b1;
                  KIND_DEBUG: r.hits.debug = 1'b1;
                  KIND_NEW:   r.was_new = 1'b1;
                  KIND_NOUN:  if (nst == 2'd2) r.hits.code = 1'b1;
                  KIND_OFF:   if (tst == 2'd2) r.hits.decision = 1'b1;
                  default:    r.was_new = r.was_new;
               endcase
            end
         end
      end
      return r;
   endfunction

   always_comb begin
      cand_in = cand_ff;
      pos_in  = pos_ff;
      prev_in = prev_ff;
      new_in  = new_ff;
      trd_in  = trd_ff;
      hits_in = hits_ff;
      cw_byte = close_word(cand_ff, pos_ff, new_ff, trd_ff);
      if (take) begin
         if (is_word(c)) begin
            if (!prev_ff) begin
               cand_in = '1;
               pos_in  = '0;
               new_in  = (new_ff == 2'd1) ? 2'd2 : 2'd0;
               trd_in  = (trd_ff == 2'd1) ? 2'd2 : 2'd0;
            end
            for (int k = 0; k < KwCount; k++) begin
               if (!(pos_in < KW_LEN[k] &&
                     (kw_char(k, pos_in) == "*" || kw_char(k, pos_in) == c)))
                  cand_in[k] = 1'b0;
            end
            if (pos_in != 4'd15) pos_in = pos_in + 4'd1;
            prev_in = 1'b1;
         end else begin
            if (prev_ff) begin
               hits_in = hits_ff | cw_byte.hits;
               new_in  = (cw_byte.was_new && is_ws(c)) ? 2'd1 : 2'd0;
               trd_in  = (cw_byte.was_trade && c != 8'd10 && c != 8'd13) ? 2'd1 : 2'd0;
            end else begin
               new_in = (new_ff == 2'd1 && is_ws(c)) ? 2'd1 : 2'd0;
               trd_in = 2'd0;
            end
            prev_in = 1'b0;
         end
      end
      // a word still open at the end of the prompt closes with no terminator
      cw_end     = close_word(cand_in, pos_in, new_in, trd_in);
      final_hits = prev_in ? (hits_in | cw_end.hits) : hits_in;
   end

   always_ff @(posedge clock) begin
      if (reset || finish) begin
         cand_ff <= '1;
         pos_ff  <= '0;
         prev_ff <= 1'b0;
         new_ff  <= '0;
         trd_ff  <= '0;
         hits_ff <= '0;
      end else begin
         cand_ff <= cand_in;
         pos_ff  <= pos_in;
         prev_ff <= prev_in;
         new_ff  <= new_in;
         trd_ff  <= trd_in;
         hits_ff <= hits_in;
      end
   end

endmodule

// ----- hw/rtl/kic_trivial_matcher.sv -----
// Trivial-prompt recognizer: trie walk over the yes/no/skip words, length count, '?' flag.
// Depends on kic_pkg.
module kic_trivial_matcher import kic_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            take,
   input  logic            finish,
   input  logic [7:0]      c,
   output triv_status_type status
);

   logic [5:0]        st_ff, st_in;
   logic [LimitW-1:0] count_ff, count_in;
   logic              seen_ff, seen_in;

   function automatic logic [5:0] tr_child(input logic [5:0] node, input logic [7:0] ch);
      logic [5:0] r;
      r = TV_ROOT;
      for (int n = 1; n <= TrNodes; n++) begin
         if (TR_PARENT[n] == node && TR_CHAR[n] == ch) r = 6'(n);
      end
      return r;
   endfunction

   function automatic logic [5:0] triv_next(input logic [5:0] st, input logic [7:0] ch);
      logic [5:0] child;
      logic       ws, pu;
      child = tr_child(st, ch);
      ws    = is_ws(ch);
      pu    = is_punct(ch);
      if (st == TV_ROOT)
         return ws ? TV_ROOT : ((child != TV_ROOT) ? child : TV_DEAD);
      if (st <= TV_LAST_NODE) begin
         if (child != TV_ROOT) return child;
         if (TR_ACC[st] && ws) return TV_AFTER_WORD;
         if (TR_ACC[st] && pu) return TV_AFTER_PUNCT;
         return TV_DEAD;
      end
      if (st == TV_AFTER_WORD) return ws ? TV_AFTER_WORD : (pu ? TV_AFTER_PUNCT : TV_DEAD);
      if (st == TV_AFTER_PUNCT) return ws ? TV_AFTER_PUNCT : TV_DEAD;
      return TV_DEAD;
   endfunction

   always_comb begin
      st_in    = st_ff;
      count_in = count_ff;
      seen_in  = seen_ff;
      if (take) begin
         st_in = triv_next(st_ff, c);
         if (count_ff != '1) count_in = count_ff + 1'b1;
         if (c == "?") seen_in = 1'b1;
      end
      status.count         = count_in;
      status.seen_question = seen_in;
      status.word_ok       = TR_ACC[st_in] || st_in == TV_AFTER_WORD ||
                             st_in == TV_AFTER_PUNCT;
   end

   always_ff @(posedge clock) begin
      if (reset || finish) begin
         st_ff    <= TV_ROOT;
         count_ff <= '0;
         seen_ff  <= 1'b0;
      end else begin
         st_ff    <= st_in;
         count_ff <= count_in;
         seen_ff  <= seen_in;
      end
   end

endmodule

// ----- hw/rtl/keyword_intent_classifier.sv -----
// Top level of the keyword intent classifier: limit registers, matchers, result register.
// Depends on kic_pkg, kic_trivial_matcher and kic_word_matcher.
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_ready  | req_text_byte, req_has_byte, req_end_of_prompt
//   rsp     | out       | rsp_valid/rsp_ready  | rsp_intent_code
//   csr     | in        | csr_valid/csr_ready  | csr_index, csr_wdata
//
// One item per cycle while req_ready is high; each byte updates the matcher registers in the cycle it is taken.
// The intent code appears in the result register in the cycle after the end-of-prompt item.
// req_ready drops only while a result waits and rsp_ready is low.
// Synchronous reset restores the limits to 30 and 8 and clears the prompt state.
// csr_ready is always high; writes to unknown indexes are dropped.
module keyword_intent_classifier import kic_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [7:0]           req_text_byte,
   input  logic                 req_has_byte,
   input  logic                 req_end_of_prompt,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [2:0]           rsp_intent_code,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CsrIndexW-1:0] csr_index,
   input  logic [LimitW-1:0]    csr_wdata
);

   logic [LimitW-1:0] short_limit_ff, tiny_limit_ff;
   logic              rsp_valid_ff;
   intent_type        rsp_code_ff, code_in;
   logic              req_fire, take, finish;
   logic [7:0]        c;
   triv_status_type   triv;
   hits_type          hits;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign take      = req_fire && req_has_byte;
   assign finish    = req_fire && req_end_of_prompt;
   assign c         = fold_lower(req_text_byte);
   assign csr_ready = 1'b1;

   kic_trivial_matcher u_triv (
      .clock  (clock),
      .reset  (reset),
      .take   (take),
      .finish (finish),
      .c      (c),
      .status (triv)
   );

   kic_word_matcher u_word (
      .clock      (clock),
      .reset      (reset),
      .take       (take),
      .finish     (finish),
      .c          (c),
      .final_hits (hits)
   );

   always_comb begin
      if (triv.count == '0)
         code_in = INTENT_DEFAULT;
      else if (triv.count < short_limit_ff &&
               (triv.word_ok || (triv.count < tiny_limit_ff && !triv.seen_question)))
         code_in = INTENT_TRIVIAL;
      else if (hits.debug)
         code_in = INTENT_DEBUG;
      else if (hits.code)
         code_in = INTENT_CODE;
      else if (hits.decision)
         code_in = INTENT_DECISION;
      else
         code_in = INTENT_DEFAULT;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         short_limit_ff <= SHORT_LIMIT_RESET;
         tiny_limit_ff  <= TINY_LIMIT_RESET;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == CSR_SHORT_LIMIT) short_limit_ff <= csr_wdata;
         if (csr_index == CSR_TINY_LIMIT) tiny_limit_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (finish) rsp_code_ff <= code_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_intent_code = rsp_code_ff;

   a_code_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_code_ff <= INTENT_DEFAULT)
      else $error("intent code out of range");

   a_empty_default: assert property (@(posedge clock) disable iff (reset)
      (finish && triv.count == '0) |=> rsp_code_ff == INTENT_DEFAULT)
      else $error("empty prompt not classified as default");

   a_ready_stall: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid_ff)
      else $error("input stalled with no result pending");

endmodule
